@@ hw/rtl/lph_pkg.sv @@
// Shared types and constants of the landmark pair hasher.
package lph_pkg;

    // Result field widths.
    localparam int KEY_W = 27;
    localparam int SEC_W = 17;

    // Configuration register widths.
    localparam int FGAP_W     = 12;
    localparam int TGAP_W     = 16;
    localparam int PAIRS_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ_GAP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ_GAP = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP_MS   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP_MS   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAIRS    = CFG_IDX_W'(4);

    // Configuration reset values.
    localparam logic [FGAP_W-1:0]  RST_MIN_FREQ_GAP = FGAP_W'(10);
    localparam logic [FGAP_W-1:0]  RST_MAX_FREQ_GAP = FGAP_W'(20);
    localparam logic [TGAP_W-1:0]  RST_MIN_GAP_MS   = TGAP_W'(200);
    localparam logic [TGAP_W-1:0]  RST_MAX_GAP_MS   = TGAP_W'(1000);
    localparam logic [PAIRS_W-1:0] RST_MAX_PAIRS    = PAIRS_W'(7);

    // Key weights: key = f1 * F1_MULT + f2 * F2_MULT + (dt >> DT_SHIFT).
    localparam int F1_MULT  = 20000;
    localparam int F2_MULT  = 100;
    localparam int DT_SHIFT = 2;

    // Milliseconds to seconds: t / 1000 = ((t >> 3) * SEC_RECIP) >> 36,
    // exact for every t below 2**32.
    localparam int SEC_PRE_SHIFT  = 3;
    localparam int SEC_NUM_W      = 29;
    localparam int SEC_RECIP_W    = 30;
    localparam int SEC_PROD_W     = SEC_NUM_W + SEC_RECIP_W;
    localparam int SEC_POST_SHIFT = 36;
    localparam logic [SEC_RECIP_W-1:0] SEC_RECIP = SEC_RECIP_W'(549755814);

    typedef struct packed {
        logic [FGAP_W-1:0]  min_freq_gap;
        logic [FGAP_W-1:0]  max_freq_gap;
        logic [TGAP_W-1:0]  min_gap_ms;
        logic [TGAP_W-1:0]  max_gap_ms;
        logic [PAIRS_W-1:0] max_pairs_per_anchor;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic shift;
        logic wrap;
    } t_cell_ctl;

    typedef struct packed {
        logic             accept;
        logic [KEY_W-1:0] hash_key;
    } t_eval;

    typedef struct packed {
        logic [KEY_W-1:0] hash_key;
        logic [SEC_W-1:0] anchor_seconds;
        logic             pair_valid;
        logic             last_of_run;
        logic             end_of_stream;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_FLUSH
    } t_state;

endpackage

@@ hw/rtl/lph_ifs.sv @@
// Handshake channel interfaces of the landmark pair hasher.
interface lph_peak_if #(
    parameter int FREQ_BITS = 12,
    parameter int TIME_BITS = 26
) ();
    logic                 valid;
    logic                 ready;
    logic [FREQ_BITS-1:0] peak_freq;
    logic [TIME_BITS-1:0] peak_time_ms;
    logic                 stream_end;

    modport source (output valid, output peak_freq, output peak_time_ms,
                    output stream_end, input ready);
    modport sink (input valid, input peak_freq, input peak_time_ms,
                  input stream_end, output ready);
endinterface

interface lph_hash_if ();
    import lph_pkg::*;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] hash_key;
    logic [SEC_W-1:0] anchor_seconds;
    logic             pair_valid;
    logic             last_of_run;
    logic             end_of_stream;

    modport source (output valid, output hash_key, output anchor_seconds,
                    output pair_valid, output last_of_run, output end_of_stream,
                    input ready);
    modport sink (input valid, input hash_key, input anchor_seconds,
                  input pair_valid, input last_of_run, input end_of_stream,
                  output ready);
endinterface

interface lph_cfg_if ();
    import lph_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    modport source (output valid, output cfg_index, output cfg_data, input ready);
    modport sink (input valid, input cfg_index, input cfg_data, output ready);
endinterface

@@ hw/rtl/lph_cell.sv @@
// One window cell: holds a peak and passes it to its lower neighbor.
module lph_cell #(
    parameter int DATA_W = 38
) (
    input  logic                 i_clk,
    input  lph_pkg::t_cell_ctl   i_ctl,
    input  logic [DATA_W-1:0]    i_load_data,
    input  logic [DATA_W-1:0]    i_next_data,
    input  logic [DATA_W-1:0]    i_wrap_data,
    output logic [DATA_W-1:0]    o_data
);

    logic [DATA_W-1:0] r_data;

    // A load takes a new peak; a shift takes the upper neighbor, or the
    // bottom cell's peak when this cell closes the rotation ring.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_load_data;
        end else if (i_ctl.shift) begin
            r_data <= i_ctl.wrap ? i_wrap_data : i_next_data;
        end
    end

    assign o_data = r_data;

endmodule

@@ hw/rtl/lph_pair_eval.sv @@
// Pair test and key formation for one anchor and one follower peak.
module lph_pair_eval #(
    parameter int FREQ_BITS = 12,
    parameter int TIME_BITS = 26
) (
    input  lph_pkg::t_cfg                    i_cfg,
    input  logic [FREQ_BITS-1:0]             i_anc_freq,
    input  logic [TIME_BITS-1:0]             i_anc_time,
    input  logic [lph_pkg::KEY_W-1:0]        i_anc_base,
    input  logic [FREQ_BITS-1:0]             i_fol_freq,
    input  logic [TIME_BITS-1:0]             i_fol_time,
    input  logic [FREQ_BITS-1:0]             i_prev_freq,
    input  logic [FREQ_BITS-1:0]             i_last_freq,
    input  logic [lph_pkg::PAIRS_W-1:0]      i_accepted,
    output lph_pkg::t_eval                   o_eval
);
    import lph_pkg::*;

    localparam int FG_W = (FREQ_BITS > FGAP_W) ? FREQ_BITS : FGAP_W;

    logic [FREQ_BITS-1:0] fgap;
    logic [FG_W-1:0]      fgap_x;
    logic [TIME_BITS-1:0] dt;
    logic                 fgap_ok;
    logic                 dt_ok;
    logic                 order_ok;
    logic                 cnt_ok;
    logic                 dup;
    logic [KEY_W-1:0]     f2_term;
    logic [KEY_W-1:0]     dt_term;

    always_comb begin
        fgap     = (i_anc_freq >= i_fol_freq) ? (i_anc_freq - i_fol_freq)
                                              : (i_fol_freq - i_anc_freq);
        fgap_x   = FG_W'(fgap);
        fgap_ok  = (fgap_x >= FG_W'(i_cfg.min_freq_gap)) &&
                   (fgap_x <= FG_W'(i_cfg.max_freq_gap));
        order_ok = (i_fol_time >= i_anc_time);
        dt       = i_fol_time - i_anc_time;
        dt_ok    = (dt >= TIME_BITS'(i_cfg.min_gap_ms)) &&
                   (dt <= TIME_BITS'(i_cfg.max_gap_ms));
        cnt_ok   = (i_accepted < i_cfg.max_pairs_per_anchor);
        // Same anchor frequency as last time and same partner as the last pair.
        dup      = (i_anc_freq == i_prev_freq) && (i_fol_freq == i_last_freq);

        f2_term  = KEY_W'(i_fol_freq) * KEY_W'(F2_MULT);
        dt_term  = KEY_W'(dt >> DT_SHIFT);

        o_eval.accept   = cnt_ok && fgap_ok && order_ok && dt_ok && !dup;
        o_eval.hash_key = i_anc_base + f2_term + dt_term;
    end

endmodule

@@ hw/rtl/landmark_pair_hasher_core.sv @@
// Top level of the landmark pair hasher: peak window, pair walk and result path.
//
// The block takes spectral peaks (frequency bin, time in ms) one item at a
// time and keeps them in a chain of WINDOW+1 cells. When the chain is full,
// the bottom cell is the anchor: it is latched together with its key base
// (f1*20000) and its whole seconds, the chain drops it, and the remaining
// followers then rotate through the bottom cell, one per cycle while the
// result path has room, where a single pair evaluator tests frequency gap,
// time gap, pair budget and the duplicate rule. Each accepted pair leaves as
// one result item with key = f1*20000 + f2*100 + dt/4 (low 27 bits). On a
// peak marked stream_end, every anchor left in the chain is walked the same
// way and a bare end-of-stream item closes the run; the chain and the
// duplicate history are then cleared, while the configuration keeps its
// values. last_of_run marks the final result item that one input item
// causes; an item that causes none produces nothing. A peak that does not
// fill the chain passes through accept, check and finish. A peak that fills
// it also walks the anchor: each of the WINDOW followers passes once through
// the bottom cell in the rotation, between the walk's entry and exit. On
// stream end each remaining anchor is walked in the same way before the end
// marker. A stalled result port pauses the walk when a second pending result
// would have nowhere to go; one finished result waits in the output register
// while the next is produced. Configuration writes are taken only while the
// block is idle.
module landmark_pair_hasher_core #(
    parameter int WINDOW    = 8,
    parameter int FREQ_BITS = 12,
    parameter int TIME_BITS = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lph_peak_if.sink    i_peak,
    lph_hash_if.source  o_hash,
    lph_cfg_if.sink     i_cfg
);
    import lph_pkg::*;

    localparam int PEAK_W = FREQ_BITS + TIME_BITS;
    localparam int HELD_W = $clog2(WINDOW + 2);

    // Control state.
    t_state                r_state;
    t_state                n_state;
    logic [HELD_W-1:0]     r_held;
    logic [HELD_W-1:0]     r_step;
    logic                  r_end;
    logic [PAIRS_W-1:0]    r_accepted;
    logic [FREQ_BITS-1:0]  r_prev_freq;
    logic [FREQ_BITS-1:0]  r_last_freq;
    t_cfg                  r_cfg;

    // Anchor latched at the start of a walk.
    logic [FREQ_BITS-1:0]  r_anc_freq;
    logic [TIME_BITS-1:0]  r_anc_time;
    logic [KEY_W-1:0]      r_anc_base;
    logic [SEC_W-1:0]      r_anc_sec;

    // Result path: one pending result and the output register.
    t_result               r_pend;
    logic                  r_pend_valid;
    t_result               r_out;
    logic                  r_out_valid;

    // Cell chain.
    logic [PEAK_W-1:0]     cell_q [WINDOW+1];
    t_cell_ctl             cell_ctl [WINDOW+1];
    logic [PEAK_W-1:0]     load_data;
    logic [FREQ_BITS-1:0]  fol_freq;
    logic [TIME_BITS-1:0]  fol_time;

    // Per-cycle decisions.
    logic                  peak_acc;
    logic                  out_free;
    logic                  can_take;
    logic                  window_full;
    logic                  walk_due;
    logic                  walk_done;
    logic                  start_walk;
    logic                  end_walk;
    logic                  rotate;
    logic                  res_new;
    logic                  res_take;
    logic                  clear_stream;
    logic                  flush;
    logic                  pend_move;
    t_result               res_data;
    t_eval                 ev;
    logic [HELD_W-1:0]     held_top;

    logic [SEC_NUM_W-1:0]  sec_num;
    logic [SEC_PROD_W-1:0] sec_prod;

    assign peak_acc    = i_peak.valid && i_peak.ready;
    assign out_free    = !r_out_valid || o_hash.ready;
    assign can_take    = !r_pend_valid || out_free;
    assign window_full = (r_held == HELD_W'(WINDOW + 1));
    assign walk_due    = window_full || (r_end && (r_held != '0));
    assign walk_done   = (r_step == r_held);
    assign held_top    = r_held - 1'b1;

    assign load_data = {i_peak.peak_freq, i_peak.peak_time_ms};
    assign fol_freq  = cell_q[0][PEAK_W-1:TIME_BITS];
    assign fol_time  = cell_q[0][TIME_BITS-1:0];

    // The chain: cell k hands its peak down to cell k-1. The top cell has no
    // upper neighbor and refeeds itself; during a walk the live cells form a
    // ring closed through the bottom cell.
    for (genvar k = 0; k <= WINDOW; k++) begin : g_cell
        logic [PEAK_W-1:0] next_data;

        if (k == WINDOW) begin : g_top
            assign next_data = cell_q[k];
        end else begin : g_mid
            assign next_data = cell_q[k+1];
        end

        always_comb begin
            cell_ctl[k].load  = peak_acc && (r_held == HELD_W'(k));
            cell_ctl[k].shift = start_walk || (rotate && (HELD_W'(k) < r_held));
            cell_ctl[k].wrap  = rotate && (HELD_W'(k) == held_top);
        end

        lph_cell #(
            .DATA_W (PEAK_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl[k]),
            .i_load_data (load_data),
            .i_next_data (next_data),
            .i_wrap_data (cell_q[0]),
            .o_data      (cell_q[k])
        );
    end

    lph_pair_eval #(
        .FREQ_BITS (FREQ_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_eval (
        .i_cfg       (r_cfg),
        .i_anc_freq  (r_anc_freq),
        .i_anc_time  (r_anc_time),
        .i_anc_base  (r_anc_base),
        .i_fol_freq  (fol_freq),
        .i_fol_time  (fol_time),
        .i_prev_freq (r_prev_freq),
        .i_last_freq (r_last_freq),
        .i_accepted  (r_accepted),
        .o_eval      (ev)
    );

    // Anchor seconds by reciprocal multiplication, registered at walk start.
    always_comb begin
        sec_num  = SEC_NUM_W'(fol_time >> SEC_PRE_SHIFT);
        sec_prod = SEC_PROD_W'(sec_num) * SEC_PROD_W'(SEC_RECIP);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (peak_acc) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (walk_due) begin
                    n_state = ST_WALK;
                end else if (r_end) begin
                    if (can_take) begin
                        n_state = ST_FLUSH;
                    end
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        start_walk   = 1'b0;
        end_walk     = 1'b0;
        rotate       = 1'b0;
        res_new      = 1'b0;
        clear_stream = 1'b0;
        flush        = 1'b0;
        res_data     = '0;
        case (r_state)
            ST_IDLE: begin
            end
            ST_CHECK: begin
                if (walk_due) begin
                    start_walk = 1'b1;
                end else if (r_end) begin
                    // Bare end marker: zero key and seconds.
                    res_new                = 1'b1;
                    res_data.end_of_stream = 1'b1;
                    clear_stream           = can_take;
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    end_walk = 1'b1;
                end else begin
                    res_new                 = ev.accept;
                    res_data.hash_key       = ev.hash_key;
                    res_data.anchor_seconds = r_anc_sec;
                    res_data.pair_valid     = 1'b1;
                    rotate                  = !ev.accept || can_take;
                end
            end
            ST_FLUSH: begin
                flush = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign res_take  = res_new && can_take;
    assign pend_move = r_pend_valid && out_free && (res_new || flush);

    // Sequencer and walk registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_held      <= '0;
            r_step      <= '0;
            r_end       <= 1'b0;
            r_accepted  <= '0;
            r_prev_freq <= '0;
            r_last_freq <= '0;
        end else begin
            r_state <= n_state;
            if (peak_acc) begin
                r_held <= r_held + 1'b1;
                r_end  <= i_peak.stream_end;
            end else if (start_walk) begin
                r_held <= held_top;
            end else if (clear_stream) begin
                r_held <= '0;
                r_end  <= 1'b0;
            end
            if (start_walk) begin
                r_step     <= '0;
                r_accepted <= '0;
            end else if (rotate) begin
                r_step <= r_step + 1'b1;
                if (ev.accept) begin
                    r_accepted <= r_accepted + 1'b1;
                end
            end
            if (clear_stream) begin
                r_last_freq <= '0;
            end else if (rotate && ev.accept) begin
                r_last_freq <= fol_freq;
            end
            if (clear_stream) begin
                r_prev_freq <= '0;
            end else if (end_walk) begin
                r_prev_freq <= r_anc_freq;
            end
        end
    end

    // Anchor registers.
    always_ff @(posedge i_clk) begin
        if (start_walk) begin
            r_anc_freq <= fol_freq;
            r_anc_time <= fol_time;
            r_anc_base <= KEY_W'(fol_freq) * KEY_W'(F1_MULT);
            r_anc_sec  <= SEC_W'(sec_prod >> SEC_POST_SHIFT);
        end
    end

    // Result path. The pending result learns it is the last of its run only
    // when the sequencer finishes the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (res_take) begin
                r_pend_valid <= 1'b1;
            end else if (pend_move) begin
                r_pend_valid <= 1'b0;
            end
            if (pend_move) begin
                r_out_valid <= 1'b1;
            end else if (o_hash.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_pend <= res_data;
        end
        if (pend_move) begin
            r_out <= '{hash_key:       r_pend.hash_key,
                       anchor_seconds: r_pend.anchor_seconds,
                       pair_valid:     r_pend.pair_valid,
                       last_of_run:    flush,
                       end_of_stream:  r_pend.end_of_stream};
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_freq_gap         <= RST_MIN_FREQ_GAP;
            r_cfg.max_freq_gap         <= RST_MAX_FREQ_GAP;
            r_cfg.min_gap_ms           <= RST_MIN_GAP_MS;
            r_cfg.max_gap_ms           <= RST_MAX_GAP_MS;
            r_cfg.max_pairs_per_anchor <= RST_MAX_PAIRS;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.cfg_index)
                CFG_MIN_FREQ_GAP: r_cfg.min_freq_gap <= FGAP_W'(i_cfg.cfg_data);
                CFG_MAX_FREQ_GAP: r_cfg.max_freq_gap <= FGAP_W'(i_cfg.cfg_data);
                CFG_MIN_GAP_MS:   r_cfg.min_gap_ms   <= i_cfg.cfg_data;
                CFG_MAX_GAP_MS:   r_cfg.max_gap_ms   <= i_cfg.cfg_data;
                CFG_MAX_PAIRS: begin
                    r_cfg.max_pairs_per_anchor <= PAIRS_W'(i_cfg.cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    assign i_peak.ready = (r_state == ST_IDLE);
    assign i_cfg.ready  = (r_state == ST_IDLE);

    assign o_hash.valid          = r_out_valid;
    assign o_hash.hash_key       = r_out.hash_key;
    assign o_hash.anchor_seconds = r_out.anchor_seconds;
    assign o_hash.pair_valid     = r_out.pair_valid;
    assign o_hash.last_of_run    = r_out.last_of_run;
    assign o_hash.end_of_stream  = r_out.end_of_stream;

`ifndef SYNTHESIS
    // A new peak always finds a free cell.
    a_room_for_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        peak_acc |-> (r_held <= HELD_W'(WINDOW)))
        else $error("peak accepted into a full cell chain");

    // The rotation never runs past the live followers.
    a_walk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_step <= r_held))
        else $error("walk step beyond follower count");

    // The pair budget of one anchor is never exceeded.
    a_pair_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_accepted <= r_cfg.max_pairs_per_anchor))
        else $error("anchor pair budget exceeded");

    // Every run has drained its pending result before the next item comes in.
    a_pend_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) && (n_state == ST_IDLE) |=> !r_pend_valid)
        else $error("pending result left behind at end of run");
`endif

endmodule
